[rtl/tlfd_pkg.sv]
// Package for the typed length frame deframer.
// Shared types, status codes and sizes; no dependencies.
`default_nettype none

package tlfd_pkg;

  localparam int unsigned HdrBytes   = 8;
  localparam int unsigned PosW       = 4;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned CfgAddrW   = 4;

  // status codes
  localparam logic [2:0] CodeOk        = 3'd0;
  localparam logic [2:0] CodeShort     = 3'd1;
  localparam logic [2:0] CodeMagic     = 3'd2;
  localparam logic [2:0] CodeVersion   = 3'd3;
  localparam logic [2:0] CodeTooLong   = 3'd4;
  localparam logic [2:0] CodeTruncated = 3'd5;

  // register indexes
  localparam logic [1:0] RegMagicFirst  = 2'd0;
  localparam logic [1:0] RegMagicSecond = 2'd1;
  localparam logic [1:0] RegVersion     = 2'd2;
  localparam logic [1:0] RegMaxLength   = 2'd3;

  // result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [7:0]  expected_version;
    logic [31:0] max_payload_length;
  } cfg_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [31:0] frame_length;
    logic [2:0]  status_code;
    logic        last_result;
  } result_t;

  // up to two results per input byte
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

[rtl/tlfd_cfg.sv]
// APB-style register file for the deframer: magic bytes, version, length limit.
// Depends on tlfd_pkg.
`default_nettype none

module tlfd_cfg
  import tlfd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        RegMagicFirst:  cfg_nxt.magic_first        = pwdata[7:0];
        RegMagicSecond: cfg_nxt.magic_second       = pwdata[7:0];
        RegVersion:     cfg_nxt.expected_version   = pwdata[7:0];
        RegMaxLength:   cfg_nxt.max_payload_length = pwdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegMagicFirst:  prdata = {24'd0, cfg_r.magic_first};
      RegMagicSecond: prdata = {24'd0, cfg_r.magic_second};
      RegVersion:     prdata = {24'd0, cfg_r.expected_version};
      RegMaxLength:   prdata = cfg_r.max_payload_length;
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/tlfd_parser.sv]
// Per-byte header check, payload count and status generation.
// Depends on tlfd_pkg.
`default_nettype none

module tlfd_parser
  import tlfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] in_byte,
  input  wire logic       buffer_end,
  input  cfg_t            cfg,
  output push_t           push
);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [7:0]      type_r, type_nxt;
  logic [31:0]     len_r, len_nxt;
  logic [31:0]     cnt_r, cnt_nxt;
  logic [2:0]      err_r, err_nxt;
  logic [31:0]     len_shift;
  result_t         pay_res, stat_res;
  logic            emit_pay;

  localparam logic [PosW-1:0] HdrEnd  = PosW'(HdrBytes);
  localparam logic [PosW-1:0] HdrLast = PosW'(HdrBytes - 1);

  assign len_shift = {len_r[23:0], in_byte};

  always_comb begin
    pos_nxt  = pos_r;
    type_nxt = type_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    emit_pay = 1'b0;
    pay_res  = '0;
    stat_res = '0;
    push     = '0;

    if (take) begin
      if (pos_r < HdrEnd) begin
        unique case (pos_r)
          PosW'(0): begin
            if (err_r == CodeOk && in_byte != cfg.magic_first) err_nxt = CodeMagic;
          end
          PosW'(1): begin
            if (err_r == CodeOk && in_byte != cfg.magic_second) err_nxt = CodeMagic;
          end
          PosW'(2): begin
            if (err_r == CodeOk && in_byte != cfg.expected_version) err_nxt = CodeVersion;
          end
          PosW'(3): begin
            type_nxt = in_byte;
          end
          default: begin
            len_nxt = len_shift;
            if (pos_r == HdrLast && err_r == CodeOk &&
                len_shift > cfg.max_payload_length) begin
              err_nxt = CodeTooLong;
            end
          end
        endcase
        pos_nxt = pos_r + PosW'(1);
      end else if (err_r == CodeOk && cnt_r < len_r) begin
        emit_pay             = 1'b1;
        cnt_nxt              = cnt_r + 32'd1;
        pay_res.result_kind  = KindPayload;
        pay_res.payload_byte = in_byte;
        pay_res.frame_type   = type_r;
        pay_res.frame_length = len_r;
      end

      if (buffer_end) begin
        stat_res.result_kind = KindStatus;
        stat_res.last_result = 1'b1;
        stat_res.frame_type   = type_nxt;
        stat_res.frame_length = len_nxt;
        // a short buffer overrides any header error and hides the header fields
        priority if (pos_nxt < HdrEnd) begin
          stat_res.status_code  = CodeShort;
          stat_res.frame_type   = 8'd0;
          stat_res.frame_length = 32'd0;
        end else if (err_nxt != CodeOk) begin
          stat_res.status_code = err_nxt;
        end else if (cnt_nxt < len_nxt) begin
          stat_res.status_code = CodeTruncated;
        end else begin
          stat_res.status_code = CodeOk;
        end
        pos_nxt  = '0;
        type_nxt = '0;
        len_nxt  = '0;
        cnt_nxt  = '0;
        err_nxt  = CodeOk;
      end

      // payload first, status behind it in the same cycle
      if (emit_pay) begin
        push.first  = pay_res;
        push.second = stat_res;
        push.count  = buffer_end ? 2'd2 : 2'd1;
      end else if (buffer_end) begin
        push.first = stat_res;
        push.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      type_r <= '0;
      len_r  <= '0;
      cnt_r  <= '0;
      err_r  <= CodeOk;
    end else begin
      pos_r  <= pos_nxt;
      type_r <= type_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/tlfd_outq.sv]
// Small result queue: takes up to two results a cycle, hands out one while out_ready is high.
// Depends on tlfd_pkg.
`default_nettype none

module tlfd_outq
  import tlfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  push_t     push,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_res
);

  result_t              slots_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QueueCntW-1:0] cnt_r, cnt_nxt;
  logic                 pop;
  logic [QueuePtrW-1:0] wr_next_slot;

  // room for a full pair of results, without counting this cycle's pop
  assign room         = cnt_r <= QueueCntW'(QueueDepth - 2);
  assign out_valid    = cnt_r != '0;
  assign out_res      = slots_r[rd_r];
  assign pop          = out_valid & out_ready;
  assign wr_next_slot = wr_r + QueuePtrW'(1);

  always_comb begin
    wr_nxt  = wr_r + QueuePtrW'(push.count);
    rd_nxt  = pop ? rd_r + QueuePtrW'(1) : rd_r;
    cnt_nxt = cnt_r + QueueCntW'(push.count) - QueueCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) slots_r[wr_r] <= push.first;
    if (push.count == 2'd2) slots_r[wr_next_slot] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/typed_length_frame_deframer_unit.sv]
// Typed length frame deframer, top level. Uses tlfd_pkg, tlfd_cfg,
// tlfd_parser and tlfd_outq.
//
// Takes one buffer byte per clock (tlast on the final byte) and checks the
// 8-byte header: two magic bytes, version, type, big-endian 32-bit length.
// Payload bytes up to the length come out as they arrive, one transfer each;
// the final byte adds a status transfer (tlast high) with type, length and
// code. A byte is taken every cycle as long as the four-entry result queue
// has two free slots, so the input runs at one byte per clock while the
// output keeps up; a final payload byte yields two result transfers.
// Results are registered in the result queue before they reach the output.
// Discard the payload of a frame whose status is not ok.
`default_nettype none

module typed_length_frame_deframer_unit
  import tlfd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input stream
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_tdata,   // [7:0] in_byte
  input  wire logic                in_tlast,   // buffer_end
  // result stream
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [55:0]              out_tdata,  // [7:0] payload_byte, [15:8] frame_type,
                                               // [47:16] frame_length, [50:48] status_code
  output logic                     out_tuser,  // result_kind
  output logic                     out_tlast,  // last_result
  // configuration
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic      [31:0]         cfg_prdata,
  output logic                     cfg_pready
);

  cfg_t    cfg;
  push_t   push;
  result_t res;
  logic    room;
  logic    take;

  assign in_tready = room;
  assign take      = in_tvalid & in_tready;

  tlfd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tlfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_byte    (in_tdata),
    .buffer_end (in_tlast),
    .cfg        (cfg),
    .push       (push)
  );

  tlfd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {5'd0, res.status_code, res.frame_length, res.frame_type,
                      res.payload_byte};
  assign out_tuser = res.result_kind;
  assign out_tlast = res.last_result;

endmodule

`default_nettype wire
